>>> rtl/iest_pkg.sv
// ----------------------------------------------------------------------------
// iest_pkg
// Shared types and codes for the input event state tracker.
// ----------------------------------------------------------------------------
package iest_pkg;

  // Device codes
  localparam logic [1:0] DEV_KBD   = 2'd0;
  localparam logic [1:0] DEV_MOUSE = 2'd1;

  // Event kind codes
  localparam logic [2:0] KIND_DOWN   = 3'd0;
  localparam logic [2:0] KIND_UP     = 3'd1;
  localparam logic [2:0] KIND_CURSOR = 3'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIRT = 2'd1;
  localparam int SIDE_W = 48;
  localparam int VIRT_W = 24;

  // Tracked modifier codes: six side keys, then three virtual keys
  localparam int MOD_SIDE  = 6;
  localparam int MOD_SLOTS = 9;
  localparam int MOD_IDX_W = 4;

  // Output queue
  localparam int OQ_DEPTH  = 4;
  localparam int OQ_PTR_W  = 2;
  localparam int OQ_CNT_W  = 3;

  // One result word
  typedef struct packed {
    logic              synthetic;
    logic [1:0]        out_device;
    logic [2:0]        out_kind;
    logic [7:0]        out_key;
    logic [2:0]        out_button;
    logic signed [15:0] cursor_x;
    logic signed [15:0] cursor_y;
    logic              last;
  } result_t;

endpackage

>>> rtl/iest_if.sv
// ----------------------------------------------------------------------------
// iest_in_if / iest_out_if
// Valid/ready channels for input event words and result words.
// ----------------------------------------------------------------------------
interface iest_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        device;
  logic [2:0]        kind;
  logic [7:0]        key_code;
  logic [2:0]        button_index;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;

  modport source (output valid, device, kind, key_code, button_index, pos_x, pos_y,
                  input ready);
  modport sink   (input valid, device, kind, key_code, button_index, pos_x, pos_y,
                  output ready);
endinterface

interface iest_out_if;
  logic              valid;
  logic              ready;
  logic              synthetic;
  logic [1:0]        out_device;
  logic [2:0]        out_kind;
  logic [7:0]        out_key;
  logic [2:0]        out_button;
  logic signed [15:0] cursor_x;
  logic signed [15:0] cursor_y;
  logic              last;

  modport source (output valid, synthetic, out_device, out_kind, out_key, out_button,
                  cursor_x, cursor_y, last, input ready);
  modport sink   (input valid, synthetic, out_device, out_kind, out_key, out_button,
                  cursor_x, cursor_y, last, output ready);
endinterface

>>> rtl/iest_out_fifo.sv
// ----------------------------------------------------------------------------
// iest_out_fifo
// Four-entry result queue; takes up to two words per cycle, sends one.
// ----------------------------------------------------------------------------
module iest_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_one,
  input  logic              push_two,
  input  iest_pkg::result_t res0,
  input  iest_pkg::result_t res1,
  output logic              has_room,
  iest_out_if.source        evt_out
);
  import iest_pkg::*;

  result_t               q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   wr_ptr;
  logic [OQ_PTR_W-1:0]   rd_ptr;
  logic [OQ_CNT_W-1:0]   count;
  logic [OQ_CNT_W-1:0]   push_n;
  logic                  pop;
  result_t               head;

  // Room for a full two-word burst
  assign has_room = count <= OQ_CNT_W'(OQ_DEPTH - 2);
  assign pop      = evt_out.valid && evt_out.ready;
  assign push_n   = push_two ? OQ_CNT_W'(2) : (push_one ? OQ_CNT_W'(1) : '0);

  // Storage writes
  always_ff @(posedge clk) begin
    if (push_one) begin
      q[wr_ptr] <= res0;
    end
    if (push_two) begin
      q[wr_ptr + OQ_PTR_W'(1)] <= res1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_PTR_W'(1);
      end
      count <= count + push_n - (pop ? OQ_CNT_W'(1) : '0);
    end
  end

  // Head word to the port
  assign head               = q[rd_ptr];
  assign evt_out.valid      = count != '0;
  assign evt_out.synthetic  = head.synthetic;
  assign evt_out.out_device = head.out_device;
  assign evt_out.out_kind   = head.out_kind;
  assign evt_out.out_key    = head.out_key;
  assign evt_out.out_button = head.out_button;
  assign evt_out.cursor_x   = head.cursor_x;
  assign evt_out.cursor_y   = head.cursor_y;
  assign evt_out.last       = head.last;

endmodule

>>> rtl/input_event_state_tracker.sv
// ----------------------------------------------------------------------------
// input_event_state_tracker
// Tracks key/button pressed state and cursor position, drops repeated
// presses and releases, and adds virtual modifier events.
// ----------------------------------------------------------------------------
// An input word is registered, then processed combinationally against the key
// and button bitmaps; its one or two result words go into a four-entry output
// queue that drains one word per cycle while the receiver is ready. A new
// input word can be taken every cycle while the queue has room for two, so
// single-result items can be sustained at one item per cycle, while items
// that also produce a virtual modifier event are bound by the one-word output
// port. The pressed state of the nine configured modifier codes is kept in
// shadow flops; after every configuration write these are reloaded from the
// key bitmap one code at a time, during which no input word is taken.
module input_event_state_tracker #(
  parameter int KEY_COUNT    = 256,
  parameter int BUTTON_COUNT = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [iest_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [iest_pkg::CFG_DATA_W-1:0] cfg_data,
  iest_in_if.sink                         evt_in,
  iest_out_if.source                      evt_out
);
  import iest_pkg::*;

  localparam int KEY_W = $clog2(KEY_COUNT);
  localparam int BTN_W = $clog2(BUTTON_COUNT);

  // Configuration
  logic [SIDE_W-1:0]    side_codes;
  logic [VIRT_W-1:0]    virt_codes;
  logic [7:0]           mod_code [MOD_SLOTS];
  logic [MOD_SLOTS-1:0] code_ok;

  // Tracked state
  logic [KEY_COUNT-1:0]    key_map;
  logic [KEY_COUNT-1:0]    key_map_next;
  logic [BUTTON_COUNT-1:0] btn_map;
  logic signed [15:0]      track_x;
  logic signed [15:0]      track_y;
  logic [MOD_SLOTS-1:0]    mod_dn;
  logic [MOD_SLOTS-1:0]    mod_upd;
  logic [MOD_SLOTS-1:0]    mod_next;

  // Shadow reload sequencer
  logic                 reload_busy;
  logic [MOD_IDX_W-1:0] reload_cnt;

  // Input register
  logic               in_valid;
  logic [1:0]         in_dev;
  logic [2:0]         in_kind;
  logic [7:0]         in_key;
  logic [2:0]         in_btn;
  logic signed [15:0] in_x;
  logic signed [15:0] in_y;

  // Processing
  logic               fire;
  logic               q_room;
  logic [KEY_W-1:0]   rd_addr;
  logic               rd_bit;
  logic               key_ok;
  logic               key_cur;
  logic               btn_ok;
  logic               btn_cur;
  logic               is_kbd;
  logic               is_mouse;
  logic               is_press;
  logic               down;
  logic               drop;
  logic               key_wr;
  logic               btn_wr;
  logic               cur_upd;
  logic               slot_hit;
  logic [1:0]         slot;
  logic               mod_now;
  logic               mod_before;
  logic [7:0]         vkey;
  logic               vkey_ok;
  logic               syn;
  logic signed [15:0] cur_x;
  logic signed [15:0] cur_y;
  result_t            res0;
  result_t            res1;

  // Modifier code table and range checks
  always_comb begin
    for (int i = 0; i < MOD_SLOTS; i++) begin
      if (i < MOD_SIDE) begin
        mod_code[i] = side_codes[8*i +: 8];
      end else begin
        mod_code[i] = virt_codes[8*(i-MOD_SIDE) +: 8];
      end
      code_ok[i] = 32'(mod_code[i]) < KEY_COUNT;
    end
  end

  // Single read port on the key bitmap
  assign rd_addr = reload_busy ? KEY_W'(mod_code[reload_cnt]) : KEY_W'(in_key);
  assign rd_bit  = key_map[rd_addr];

  // Handshake
  assign fire         = in_valid && q_room;
  assign evt_in.ready = !reload_busy && (!in_valid || fire);

  // Event decode and duplicate filtering
  assign is_kbd   = in_dev == DEV_KBD;
  assign is_mouse = in_dev == DEV_MOUSE;
  assign is_press = (in_kind == KIND_DOWN) || (in_kind == KIND_UP);
  assign down     = in_kind == KIND_DOWN;
  assign key_ok   = 32'(in_key) < KEY_COUNT;
  assign key_cur  = key_ok && rd_bit;
  assign btn_ok   = 32'(in_btn) < BUTTON_COUNT;
  assign btn_cur  = btn_ok && btn_map[BTN_W'(in_btn)];
  assign drop     = is_press && ((is_kbd && key_cur == down) ||
                                 (is_mouse && btn_cur == down));
  assign key_wr   = is_kbd && is_press && !drop;
  assign btn_wr   = is_mouse && is_press && !drop;
  assign cur_upd  = is_mouse && in_kind == KIND_CURSOR;

  // Modifier slot search, shift first
  always_comb begin
    slot_hit = 1'b0;
    slot     = '0;
    for (int i = 2; i >= 0; i--) begin
      if (in_key == mod_code[2*i] || in_key == mod_code[2*i+1]) begin
        slot_hit = 1'b1;
        slot     = 2'(i);
      end
    end
  end

  // Shadow state after the key write
  always_comb begin
    for (int j = 0; j < MOD_SLOTS; j++) begin
      mod_upd[j] = (key_wr && key_ok && mod_code[j] == in_key) ? down : mod_dn[j];
    end
  end

  // Combined side state against the virtual key
  always_comb begin
    mod_now    = 1'b0;
    mod_before = 1'b0;
    vkey       = '0;
    for (int i = 0; i < 3; i++) begin
      if (slot == 2'(i)) begin
        mod_now    = mod_upd[2*i] || mod_upd[2*i+1];
        mod_before = mod_upd[MOD_SIDE+i];
        vkey       = mod_code[MOD_SIDE+i];
      end
    end
  end

  assign syn     = key_wr && slot_hit && (mod_now != mod_before);
  assign vkey_ok = 32'(vkey) < KEY_COUNT;

  // Shadow state after the virtual key write
  always_comb begin
    for (int j = 0; j < MOD_SLOTS; j++) begin
      mod_next[j] = (syn && vkey_ok && mod_code[j] == vkey) ? mod_now : mod_upd[j];
    end
  end

  // Key bitmap after this item; virtual key write lands last
  always_comb begin
    key_map_next = key_map;
    if (key_wr && key_ok) begin
      key_map_next[KEY_W'(in_key)] = down;
    end
    if (syn && vkey_ok) begin
      key_map_next[KEY_W'(vkey)] = mod_now;
    end
  end

  // Result words
  assign cur_x = cur_upd ? in_x : track_x;
  assign cur_y = cur_upd ? in_y : track_y;

  always_comb begin
    res0.synthetic  = 1'b0;
    res0.out_device = in_dev;
    res0.out_kind   = in_kind;
    res0.out_key    = is_kbd ? in_key : '0;
    res0.out_button = is_mouse ? in_btn : '0;
    res0.cursor_x   = cur_x;
    res0.cursor_y   = cur_y;
    res0.last       = !syn;

    res1.synthetic  = 1'b1;
    res1.out_device = DEV_KBD;
    res1.out_kind   = mod_now ? KIND_DOWN : KIND_UP;
    res1.out_key    = vkey;
    res1.out_button = '0;
    res1.cursor_x   = cur_x;
    res1.cursor_y   = cur_y;
    res1.last       = 1'b1;
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (evt_in.valid && evt_in.ready) begin
      in_dev  <= evt_in.device;
      in_kind <= evt_in.kind;
      in_key  <= evt_in.key_code;
      in_btn  <= evt_in.button_index;
      in_x    <= evt_in.pos_x;
      in_y    <= evt_in.pos_y;
    end
  end

  // Control, configuration and tracked state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      side_codes  <= '0;
      virt_codes  <= '0;
      key_map     <= '0;
      btn_map     <= '0;
      track_x     <= '0;
      track_y     <= '0;
      mod_dn      <= '0;
      reload_busy <= 1'b0;
      reload_cnt  <= '0;
    end else begin
      if (evt_in.valid && evt_in.ready) begin
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end

      // Register writes restart the shadow reload
      if (cfg_we) begin
        if (cfg_index == CFG_SIDE) begin
          side_codes <= cfg_data[SIDE_W-1:0];
        end else if (cfg_index == CFG_VIRT) begin
          virt_codes <= cfg_data[VIRT_W-1:0];
        end
        reload_busy <= 1'b1;
        reload_cnt  <= '0;
      end else if (reload_busy) begin
        if (!fire) begin
          mod_dn[reload_cnt] <= code_ok[reload_cnt] && rd_bit;
        end
        if (reload_cnt == MOD_IDX_W'(MOD_SLOTS - 1)) begin
          reload_busy <= 1'b0;
        end
        reload_cnt <= reload_cnt + MOD_IDX_W'(1);
      end

      // Per-item state update
      if (fire) begin
        key_map <= key_map_next;
        if (btn_wr && btn_ok) begin
          btn_map[BTN_W'(in_btn)] <= down;
        end
        if (cur_upd) begin
          track_x <= in_x;
          track_y <= in_y;
        end
        mod_dn <= mod_next;
      end
    end
  end

  // Output queue
  iest_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_one (fire && !drop),
    .push_two (fire && syn),
    .res0     (res0),
    .res1     (res1),
    .has_room (q_room),
    .evt_out  (evt_out)
  );

endmodule

>>> test/input_event_state_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_event_state_tracker_test
// Self-checking bench for the input event state tracker. Event words go in
// through the input channel with random gaps, and the result channel stalls
// at random. A local tracker model keeps its own key, button and cursor
// state and predicts every forwarded and virtual modifier word. Phases cover
// reset defaults, modifier pairs, overlapping codes and random traffic under
// several modifier code settings.
// ----------------------------------------------------------------------------
module input_event_state_tracker_test;
  import iest_pkg::*;

  // Codes not named in the package
  localparam logic [1:0] DEV_PAD     = 2'd2;
  localparam logic [1:0] DEV_UNKNOWN = 2'd3;
  localparam logic [2:0] KIND_CHAR   = 3'd2;
  localparam logic [2:0] KIND_RAW    = 3'd2;
  localparam logic [2:0] KIND_DCLICK = 3'd4;
  localparam logic [2:0] KIND_MAX    = 3'd7;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS   = 155;

  typedef struct packed {
    logic [1:0]         device;
    logic [2:0]         kind;
    logic [7:0]         key_code;
    logic [2:0]         button_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } event_word_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  iest_in_if  evt_in_if ();
  iest_out_if evt_out_if ();

  input_event_state_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt_in    (evt_in_if),
    .evt_out   (evt_out_if)
  );

  // Tracker model state
  logic [255:0]       key_pressed;
  logic [7:0]         button_pressed;
  logic signed [15:0] cursor_x_now;
  logic signed [15:0] cursor_y_now;
  logic [SIDE_W-1:0]  side_codes;
  logic [VIRT_W-1:0]  virt_codes;
  result_t            forwarded_words[$];

  int  mismatch_count;
  int  cycle_count;
  bit  idle_on;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("input_event_state_tracker_test NOT OK");
      $finish;
    end
  end

  // Gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic result_t make_result(input logic syn, input logic [1:0] dev,
                                          input logic [2:0] kind, input logic [7:0] key,
                                          input logic [2:0] btn, input logic fin);
    result_t r;
    r.synthetic  = syn;
    r.out_device = dev;
    r.out_kind   = kind;
    r.out_key    = key;
    r.out_button = btn;
    r.cursor_x   = cursor_x_now;
    r.cursor_y   = cursor_y_now;
    r.last       = fin;
    return r;
  endfunction

  function automatic event_word_t make_event(input logic [1:0] dev, input logic [2:0] kind,
                                             input logic [7:0] key, input logic [2:0] btn,
                                             input logic [15:0] x, input logic [15:0] y);
    event_word_t ev;
    ev.device       = dev;
    ev.kind         = kind;
    ev.key_code     = key;
    ev.button_index = btn;
    ev.pos_x        = x;
    ev.pos_y        = y;
    return ev;
  endfunction

  // Append one predicted word at the tail
  task automatic expect_word(input result_t w);
    forwarded_words.insert(forwarded_words.size(), w);
  endtask

  // Update the tracked state for one accepted word and queue its results
  task automatic track_event(input event_word_t ev);
    int slot;
    int i;
    logic down;
    logic now_down;
    logic [7:0] vkey;
    slot = -1;
    case (ev.device)
      DEV_KBD: begin
        if (ev.kind == KIND_DOWN || ev.kind == KIND_UP) begin
          down = (ev.kind == KIND_DOWN);
          // repeated press or release is dropped
          if (key_pressed[ev.key_code] != down) begin
            key_pressed[ev.key_code] = down;
            // shift wins over control, control over alt
            for (i = 0; i < 3 && slot < 0; i++) begin
              if (ev.key_code == side_codes[16*i +: 8] ||
                  ev.key_code == side_codes[16*i+8 +: 8]) slot = i;
            end
            if (slot < 0) begin
              expect_word(make_result(1'b0, ev.device, ev.kind, ev.key_code,
                                      3'd0, 1'b1));
            end else begin
              now_down = key_pressed[side_codes[16*slot +: 8]] |
                         key_pressed[side_codes[16*slot+8 +: 8]];
              vkey = virt_codes[8*slot +: 8];
              if (now_down == key_pressed[vkey]) begin
                expect_word(make_result(1'b0, ev.device, ev.kind, ev.key_code,
                                        3'd0, 1'b1));
              end else begin
                // virtual key follows; it starts no modifier processing of its own
                expect_word(make_result(1'b0, ev.device, ev.kind, ev.key_code,
                                        3'd0, 1'b0));
                key_pressed[vkey] = now_down;
                expect_word(make_result(1'b1, DEV_KBD,
                                        now_down ? KIND_DOWN : KIND_UP,
                                        vkey, 3'd0, 1'b1));
              end
            end
          end
        end else begin
          // character and unknown kinds pass unchanged
          expect_word(make_result(1'b0, ev.device, ev.kind, ev.key_code,
                                  3'd0, 1'b1));
        end
      end
      DEV_MOUSE: begin
        if (ev.kind == KIND_DOWN || ev.kind == KIND_UP) begin
          down = (ev.kind == KIND_DOWN);
          if (button_pressed[ev.button_index] != down) begin
            button_pressed[ev.button_index] = down;
            expect_word(make_result(1'b0, ev.device, ev.kind, 8'd0,
                                    ev.button_index, 1'b1));
          end
        end else begin
          if (ev.kind == KIND_CURSOR) begin
            cursor_x_now = ev.pos_x;
            cursor_y_now = ev.pos_y;
          end
          expect_word(make_result(1'b0, ev.device, ev.kind, 8'd0,
                                  ev.button_index, 1'b1));
        end
      end
      default: begin
        expect_word(make_result(1'b0, ev.device, ev.kind, 8'd0, 3'd0, 1'b1));
      end
    endcase
  endtask

  // Send one event word; valid stays high after acceptance until the next call
  task automatic send_event(input event_word_t ev);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      evt_in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    evt_in_if.valid        <= 1'b1;
    evt_in_if.device       <= ev.device;
    evt_in_if.kind         <= ev.kind;
    evt_in_if.key_code     <= ev.key_code;
    evt_in_if.button_index <= ev.button_index;
    evt_in_if.pos_x        <= ev.pos_x;
    evt_in_if.pos_y        <= ev.pos_y;
    do @(posedge clk); while (!evt_in_if.ready);
    track_event(ev);
  endtask

  // Drop valid, wait for all results, then let dropped words clear the pipe
  task automatic wait_idle();
    @(negedge clk);
    evt_in_if.valid <= 1'b0;
    while (forwarded_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SIDE) side_codes = data[SIDE_W-1:0];
    else if (idx == CFG_VIRT) virt_codes = data[VIRT_W-1:0];
  endtask

  // Result sink: random stalls on ready
  initial begin
    int stall;
    stall = 0;
    evt_out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        evt_out_if.ready <= 1'b0;
        stall--;
      end else begin
        evt_out_if.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_result
    result_t want;
    result_t got;
    if (!rst && evt_out_if.valid && evt_out_if.ready) begin
      got.synthetic  = evt_out_if.synthetic;
      got.out_device = evt_out_if.out_device;
      got.out_kind   = evt_out_if.out_kind;
      got.out_key    = evt_out_if.out_key;
      got.out_button = evt_out_if.out_button;
      got.cursor_x   = evt_out_if.cursor_x;
      got.cursor_y   = evt_out_if.cursor_y;
      got.last       = evt_out_if.last;
      if (forwarded_words.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", got));
      end else begin
        want = forwarded_words.pop_front();
        if (got.synthetic !== want.synthetic)
          report_mismatch($sformatf("synthetic got %b want %b", got.synthetic, want.synthetic));
        if (got.out_device !== want.out_device)
          report_mismatch($sformatf("out_device got %0d want %0d", got.out_device,
                                    want.out_device));
        if (got.out_kind !== want.out_kind)
          report_mismatch($sformatf("out_kind got %0d want %0d", got.out_kind, want.out_kind));
        if (got.out_key !== want.out_key)
          report_mismatch($sformatf("out_key got %h want %h", got.out_key, want.out_key));
        if (got.out_button !== want.out_button)
          report_mismatch($sformatf("out_button got %0d want %0d", got.out_button,
                                    want.out_button));
        if (got.cursor_x !== want.cursor_x)
          report_mismatch($sformatf("cursor_x got %0d want %0d", got.cursor_x, want.cursor_x));
        if (got.cursor_y !== want.cursor_y)
          report_mismatch($sformatf("cursor_y got %0d want %0d", got.cursor_y, want.cursor_y));
        if (got.last !== want.last)
          report_mismatch($sformatf("last got %b want %b", got.last, want.last));
      end
    end
  end

  // Reset codes are all zero: key 0 is every side key and every virtual key
  task automatic test_reset_state();
    send_event(make_event(DEV_KBD, KIND_DOWN, 8'h00, 3'd7, 16'h0000, 16'hFFFF));
    send_event(make_event(DEV_KBD, KIND_DOWN, 8'h00, 3'd0, 16'h0000, 16'h0000));
    send_event(make_event(DEV_KBD, KIND_UP, 8'h00, 3'd0, 16'h0000, 16'h0000));
    send_event(make_event(DEV_KBD, KIND_DOWN, 8'hFF, 3'd0, 16'h0000, 16'h0000));
    send_event(make_event(DEV_KBD, KIND_CHAR, 8'hA5, 3'd5, 16'h1234, 16'h4321));
    send_event(make_event(DEV_KBD, KIND_MAX, 8'h5A, 3'd2, 16'h0000, 16'h0000));
    send_event(make_event(DEV_MOUSE, KIND_DOWN, 8'hFF, 3'd7, 16'h0000, 16'h0000));
    send_event(make_event(DEV_MOUSE, KIND_DOWN, 8'h00, 3'd7, 16'h0000, 16'h0000));
    send_event(make_event(DEV_MOUSE, KIND_UP, 8'h00, 3'd0, 16'h0000, 16'h0000));
    send_event(make_event(DEV_MOUSE, KIND_CURSOR, 8'h00, 3'd1, 16'h8000, 16'h7FFF));
    send_event(make_event(DEV_MOUSE, KIND_CURSOR, 8'h00, 3'd1, 16'h7FFF, 16'h8000));
    send_event(make_event(DEV_MOUSE, KIND_RAW, 8'h00, 3'd4, 16'h0001, 16'h0002));
    send_event(make_event(DEV_MOUSE, KIND_DCLICK, 8'h00, 3'd3, 16'h0000, 16'h0000));
    send_event(make_event(DEV_PAD, KIND_DOWN, 8'h33, 3'd6, 16'h5555, 16'hAAAA));
    send_event(make_event(DEV_UNKNOWN, 3'd5, 8'hC3, 3'd5, 16'hAAAA, 16'h5555));
  endtask

  // Left/right pairs merge into one virtual modifier per slot
  task automatic test_modifier_tracking();
    wait_idle();
    write_reg(CFG_SIDE, 48'h4B4A_3B3A_2B2A);
    write_reg(CFG_VIRT, 48'h0000_00C3_C2C1);
    send_event(make_event(DEV_KBD, KIND_DOWN, 8'h2A, 3'd0, 16'h0000, 16'h0000));
    send_event(make_event(DEV_KBD, KIND_DOWN, 8'h2B, 3'd0, 16'h0000, 16'h0000));
    send_event(make_event(DEV_KBD, KIND_UP, 8'h2A, 3'd0, 16'h0000, 16'h0000));
    send_event(make_event(DEV_KBD, KIND_UP, 8'h2B, 3'd0, 16'h0000, 16'h0000));
    send_event(make_event(DEV_KBD, KIND_DOWN, 8'h3B, 3'd0, 16'h0000, 16'h0000));
    send_event(make_event(DEV_KBD, KIND_UP, 8'h3B, 3'd0, 16'h0000, 16'h0000));
    send_event(make_event(DEV_KBD, KIND_DOWN, 8'h4A, 3'd0, 16'h0000, 16'h0000));
    // virtual alt released directly, then the side key no longer changes it
    send_event(make_event(DEV_KBD, KIND_UP, 8'hC3, 3'd0, 16'h0000, 16'h0000));
    send_event(make_event(DEV_KBD, KIND_UP, 8'h4A, 3'd0, 16'h0000, 16'h0000));
  endtask

  // Shift right shares its code with control left; virtual shift is alt left
  task automatic test_overlapping_codes();
    wait_idle();
    write_reg(CFG_SIDE, 48'h4140_3020_2010);
    write_reg(CFG_VIRT, 48'h0000_0051_5040);
    send_event(make_event(DEV_KBD, KIND_DOWN, 8'h20, 3'd0, 16'h0000, 16'h0000));
    send_event(make_event(DEV_KBD, KIND_DOWN, 8'h40, 3'd0, 16'h0000, 16'h0000));
    send_event(make_event(DEV_KBD, KIND_UP, 8'h20, 3'd0, 16'h0000, 16'h0000));
    send_event(make_event(DEV_KBD, KIND_DOWN, 8'h40, 3'd0, 16'h0000, 16'h0000));
    send_event(make_event(DEV_KBD, KIND_UP, 8'h40, 3'd0, 16'h0000, 16'h0000));
  endtask

  // Random word, mostly key presses and releases on configured codes
  function automatic event_word_t random_event();
    event_word_t ev;
    int r;
    int k;
    ev.device       = DEV_KBD;
    ev.kind         = 3'($urandom_range(0, 1));
    ev.key_code     = 8'($urandom);
    ev.button_index = 3'($urandom);
    ev.pos_x        = 16'($urandom);
    ev.pos_y        = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      k = $urandom_range(0, 8);
      ev.key_code = (k < 6) ? side_codes[8*k +: 8] : virt_codes[8*(k-6) +: 8];
    end else if (r < 65) begin
      // random key code, press or release
    end else if (r < 70) begin
      ev.kind = 3'($urandom_range(2, 7));
    end else if (r < 85) begin
      ev.device = DEV_MOUSE;
      if ($urandom_range(0, 9) < 3) ev.kind = 3'($urandom_range(0, 7));
    end else if (r < 93) begin
      ev.device = DEV_MOUSE;
      ev.kind   = KIND_CURSOR;
    end else begin
      ev.device = 2'($urandom_range(2, 3));
      ev.kind   = 3'($urandom_range(0, 7));
    end
    return ev;
  endfunction

  // Random traffic under several code settings, extremes among them
  task automatic test_random_traffic();
    int phase;
    int n;
    logic [7:0] pool [4];
    logic [CFG_DATA_W-1:0] side_word;
    logic [CFG_DATA_W-1:0] virt_word;
    for (phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          side_word = CFG_DATA_W'({$urandom, $urandom});
          virt_word = CFG_DATA_W'({$urandom, $urandom});
        end
        1: begin
          side_word = '1;
          virt_word = '1;
        end
        2: begin
          // few distinct codes, so slots and virtual keys collide
          for (n = 0; n < 4; n++) pool[n] = 8'($urandom);
          for (n = 0; n < 6; n++) side_word[8*n +: 8] = pool[2'($urandom_range(0, 3))];
          virt_word = '0;
          for (n = 0; n < 3; n++) virt_word[8*n +: 8] = pool[2'($urandom_range(0, 3))];
        end
        default: begin
          side_word = '0;
          virt_word = '0;
        end
      endcase
      write_reg(CFG_SIDE, side_word);
      write_reg(CFG_VIRT, virt_word);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
        send_event(random_event());
      end
      idle_on = 1'b1;
    end
  endtask

  // Main sequence
  initial begin
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_data               = '0;
    evt_in_if.valid        = 1'b0;
    evt_in_if.device       = '0;
    evt_in_if.kind         = '0;
    evt_in_if.key_code     = '0;
    evt_in_if.button_index = '0;
    evt_in_if.pos_x        = '0;
    evt_in_if.pos_y        = '0;
    key_pressed            = '0;
    button_pressed         = '0;
    cursor_x_now           = '0;
    cursor_y_now           = '0;
    side_codes             = '0;
    virt_codes             = '0;
    mismatch_count         = 0;
    idle_on                = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_modifier_tracking();
    test_overlapping_codes();
    test_random_traffic();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("input_event_state_tracker_test OK");
    end else begin
      $display("input_event_state_tracker_test NOT OK");
    end
    $finish;
  end

endmodule
